// ===== hdl/battery_charge_supervisor_core_macros.svh =====
// Assertion macros for the charge supervisor controller.
// Each expects signals clk and rst_n in the module that uses it.
`ifndef BATTERY_CHARGE_SUPERVISOR_CORE_MACROS_SVH
`define BATTERY_CHARGE_SUPERVISOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define BCS_CHECK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcs check failed");
// Next-cycle implication.
`define BCS_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcs check failed");
`else
`define BCS_CHECK_NOW(label, ante, cons)
`define BCS_CHECK_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/bcs_pkg.sv =====
package bcs_pkg;

  // Controller states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  // Divider width in bits (one quotient bit per step)
  localparam int DivBits = 32;
  localparam int CntW    = $clog2(DivBits);

  // Register indexes
  localparam logic [2:0] REG_MIN_CAP    = 3'd0;
  localparam logic [2:0] REG_HIGH_BLOCK = 3'd1;
  localparam logic [2:0] REG_HIGH_REC   = 3'd2;
  localparam logic [2:0] REG_LOW_REC    = 3'd3;
  localparam logic [2:0] REG_LOW_BLOCK  = 3'd4;
  localparam logic [2:0] REG_FULL_UV    = 3'd5;
  localparam logic [2:0] REG_RECHG_UV   = 3'd6;
  localparam logic [2:0] REG_LIMIT_S    = 3'd7;

  // Health codes
  localparam logic [1:0] HEALTH_GOOD    = 2'd0;
  localparam logic [1:0] HEALTH_HOT     = 2'd1;
  localparam logic [1:0] HEALTH_COLD    = 2'd2;
  localparam logic [1:0] HEALTH_UNKNOWN = 2'd3;

  // Charge machine codes
  localparam logic [1:0] CHG_OK       = 2'd0;
  localparam logic [1:0] CHG_FULL     = 2'd1;
  localparam logic [1:0] CHG_BAD_TEMP = 2'd2;
  localparam logic [1:0] CHG_TIMEOUT  = 2'd3;

  // Drive codes
  localparam logic [1:0] DRV_NONE    = 2'd0;
  localparam logic [1:0] DRV_DISABLE = 2'd1;
  localparam logic [1:0] DRV_ENABLE  = 2'd2;

  // Supply status codes
  localparam logic [2:0] STAT_UNKNOWN  = 3'd0;
  localparam logic [2:0] STAT_CHARGING = 3'd1;
  localparam logic [2:0] STAT_DISCHG   = 3'd2;
  localparam logic [2:0] STAT_NOT_CHG  = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;

  localparam logic [31:0] RECHARGE_LIMIT_S = 32'd5400;

  typedef struct packed {
    logic capture;
    logic mul;
    logic load;
    logic step;
    logic update;
  } bcs_cmd_t;

  typedef struct packed {
    logic out_busy;
  } bcs_stat_t;

endpackage

// ===== hdl/bcs_ctrl.sv =====
`include "battery_charge_supervisor_core_macros.svh"
module bcs_ctrl import bcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  bcs_stat_t stat,
  output bcs_cmd_t  cmd
);

  logic [2:0]      state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            take;

  assign in_tready = (state_r == S_IDLE);
  assign take      = in_tvalid && in_tready;

  // Sequence one poll: capture, multiply, load divider, shift, commit
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.capture = take;
        if (take) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CntW'(DivBits - 1)) state_nxt = S_UPD;
      end
      S_UPD: begin
        if (!stat.out_busy) begin
          cmd.update = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `BCS_CHECK_NEXT(a_take_mul, take, state_r == S_MUL)
  `BCS_CHECK_NEXT(a_div_end, (state_r == S_DIV) && (cnt_r == CntW'(DivBits - 1)), state_r == S_UPD)
  `BCS_CHECK_NOW(a_upd_free, cmd.update, !stat.out_busy)

endmodule

// ===== hdl/bcs_dp.sv =====
module bcs_dp import bcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  bcs_cmd_t    cmd,
  output bcs_stat_t   stat,
  input  logic [87:0] in_tdata,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [22:0] cfg_wdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata
);

  // Configuration registers
  logic [6:0]         min_cap_r;
  logic signed [11:0] high_block_r, high_rec_r, low_rec_r, low_block_r;
  logic [22:0]        full_uv_r, rechg_uv_r;
  logic [15:0]        limit_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_cap_r    <= 7'd0;
      high_block_r <= 12'sd500;
      high_rec_r   <= 12'sd420;
      low_rec_r    <= 12'sd0;
      low_block_r  <= -12'sd50;
      full_uv_r    <= 23'd4150000;
      rechg_uv_r   <= 23'd4140000;
      limit_s_r    <= 16'd21600;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_MIN_CAP:    min_cap_r    <= cfg_wdata[6:0];
        REG_HIGH_BLOCK: high_block_r <= cfg_wdata[11:0];
        REG_HIGH_REC:   high_rec_r   <= cfg_wdata[11:0];
        REG_LOW_REC:    low_rec_r    <= cfg_wdata[11:0];
        REG_LOW_BLOCK:  low_block_r  <= cfg_wdata[11:0];
        REG_FULL_UV:    full_uv_r    <= cfg_wdata;
        REG_RECHG_UV:   rechg_uv_r   <= cfg_wdata;
        REG_LIMIT_S:    limit_s_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Captured poll word
  logic [87:0] poll_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) poll_r <= in_tdata;
  end

  logic [15:0]        p_vraw, p_sraw;
  logic               p_vok, p_sok, p_tok, p_pres, p_act, p_full;
  logic signed [11:0] p_temp;
  logic [31:0]        p_now;
  assign p_vraw = poll_r[15:0];
  assign p_vok  = poll_r[16];
  assign p_sraw = poll_r[32:17];
  assign p_sok  = poll_r[33];
  assign p_temp = poll_r[45:34];
  assign p_tok  = poll_r[46];
  assign p_pres = poll_r[47];
  assign p_act  = poll_r[48];
  assign p_full = poll_r[49];
  assign p_now  = poll_r[81:50];

  // Rescale front end: clamp minimum to 99, scale the span by 25600
  logic [6:0]  m_eff;
  logic [15:0] fmin_eff;
  logic [14:0] div_d;
  logic        soc_empty;
  assign m_eff     = (min_cap_r > 7'd99) ? 7'd99 : min_cap_r;
  assign fmin_eff  = {2'b00, m_eff, 7'd0} << 1;
  assign div_d     = 15'(16'd25600 - fmin_eff);
  assign soc_empty = (p_sraw <= {1'b0, min_cap_r, 8'd0});

  logic [30:0] prod_r;
  logic [22:0] vcell_new_r;
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r      <= 31'(p_sraw - fmin_eff) * 31'd25600;
      vcell_new_r <= 23'(p_vraw[15:4]) * 23'd1250;
    end
  end

  // Bit-serial restoring divider
  logic [22:0]         scaled;
  logic [31:0]         num;
  logic [DivBits-1:0]  quo_r;
  logic [14:0]         rem_r;
  logic [15:0]         rem_sh;
  logic                q_bit;
  assign scaled = 23'((32'(prod_r) + 32'd128) >> 8);
  assign num    = {1'b0, scaled, 8'd0} + 32'(div_d >> 1);
  assign rem_sh = {rem_r, quo_r[DivBits-1]};
  assign q_bit  = (rem_sh >= {1'b0, div_d});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r <= num;
      rem_r <= '0;
    end else if (cmd.step) begin
      rem_r <= q_bit ? 15'(rem_sh - {1'b0, div_d}) : rem_sh[14:0];
      quo_r <= {quo_r[DivBits-2:0], q_bit};
    end
  end

  // Supervisor state
  logic [22:0]        vcell_r, vcell_n;
  logic [6:0]         soc_r, soc_n, soc_calc;
  logic signed [11:0] temp_r, temp_n;
  logic [1:0]         health_r, health_n, fsm_r, fsm_n, drive_n;
  logic [31:0]        dl_r, dl_n;
  logic               rf_r, rf_n, in_win;
  logic [2:0]         stat_r, stat_n;

  assign soc_calc = soc_empty ? 7'd0 :
                    (quo_r[31:8] > 24'd100) ? 7'd100 : quo_r[14:8];
  assign in_win   = (temp_n <= high_rec_r) && (temp_n >= low_rec_r);

  // Commit logic for one poll
  always_comb begin
    vcell_n  = p_vok ? vcell_new_r : vcell_r;
    soc_n    = p_sok ? soc_calc : soc_r;
    temp_n   = p_tok ? p_temp : temp_r;
    health_n = health_r;
    fsm_n    = fsm_r;
    dl_n     = dl_r;
    rf_n     = rf_r;
    drive_n  = DRV_NONE;
    stat_n   = stat_r;
    if (!p_tok) health_n = HEALTH_UNKNOWN;
    else if (p_temp >= high_block_r) health_n = HEALTH_HOT;
    else if (in_win) health_n = HEALTH_GOOD;
    else if (p_temp <= low_block_r) health_n = HEALTH_COLD;

    if (p_pres) begin
      case (fsm_r)
        CHG_OK: begin
          if (p_full && soc_n >= 7'd100 && vcell_n > full_uv_r) begin
            fsm_n = CHG_FULL; rf_n = 1'b1; dl_n = '0; drive_n = DRV_DISABLE;
          end else if (dl_r != '0 && p_now > dl_r) begin
            fsm_n = CHG_TIMEOUT; rf_n = 1'b1; dl_n = '0; drive_n = DRV_DISABLE;
          end else if (health_n == HEALTH_HOT || health_n == HEALTH_COLD) begin
            fsm_n = CHG_BAD_TEMP; dl_n = '0; drive_n = DRV_DISABLE;
          end
        end
        CHG_FULL: begin
          if (vcell_n <= rechg_uv_r) begin fsm_n = CHG_OK; drive_n = DRV_ENABLE; end
        end
        CHG_BAD_TEMP: begin
          if (in_win) begin fsm_n = CHG_OK; drive_n = DRV_ENABLE; end
        end
        default: begin
          if (vcell_n <= full_uv_r) begin fsm_n = CHG_OK; drive_n = DRV_ENABLE; end
        end
      endcase
      if (dl_n == '0 && fsm_n == CHG_OK)
        dl_n = p_now + (rf_n ? RECHARGE_LIMIT_S : 32'(limit_s_r));
      if (p_act) stat_n = STAT_CHARGING;
      else stat_n = (fsm_n == CHG_FULL) ? STAT_FULL : STAT_NOT_CHG;
    end else begin
      rf_n   = 1'b0;
      stat_n = STAT_DISCHG;
      dl_n   = '0;
      fsm_n  = CHG_OK;
    end
  end

  logic out_valid_r;
  logic [39:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcell_r  <= '0;
      soc_r    <= '0;
      temp_r   <= '0;
      health_r <= HEALTH_GOOD;
      fsm_r    <= CHG_OK;
      dl_r     <= '0;
      rf_r     <= 1'b0;
      stat_r   <= STAT_UNKNOWN;
    end else if (cmd.update) begin
      vcell_r  <= vcell_n;
      soc_r    <= soc_n;
      temp_r   <= temp_n;
      health_r <= health_n;
      fsm_r    <= fsm_n;
      dl_r     <= dl_n;
      rf_r     <= rf_n;
      stat_r   <= stat_n;
    end
  end

  // Output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.update) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.update)
      out_data_r <= {(soc_n != soc_r) || (stat_n != stat_r), stat_n, drive_n,
                     fsm_n, health_n, vcell_n, soc_n};
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign stat.out_busy = out_valid_r && !out_tready;

endmodule

// ===== hdl/battery_charge_supervisor_core.sv =====
// Li-ion charge supervisor. Each input word is one poll (raw voltage and SOC
// words, temperature, charger lines, time); each poll yields exactly one result
// word with rescaled SOC, cell voltage, health, charge state, charger drive,
// supply status and a changed flag. A poll passes in order through capture,
// multiply, divider load, 32 steps of the bit-serial SOC divider and commit;
// no new poll is accepted before the commit. The commit waits while a previous
// result is still held unread in the output register.
// Configuration writes are taken at any time but must be made only while idle.
module battery_charge_supervisor_core import bcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // vcell_raw[15:0], vcell_ok[16], soc_raw[32:17], soc_ok[33],
  // temp_reading[45:34], temp_ok[46], charger_present[47],
  // charging_active[48], charger_full_flag[49], now_seconds[81:50], zero fill
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // soc_percent[6:0], vcell_uv[29:7], health[31:30], charge_state[33:32],
  // charge_drive[35:34], supply_status[38:36], changed[39]
  output logic [39:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [22:0] cfg_wdata
);

  bcs_cmd_t  cmd;
  bcs_stat_t stat;

  bcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bcs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== tb/tb_battery_charge_supervisor_core.sv =====
`timescale 1ns / 100ps

module tb_battery_charge_supervisor_core;
  import bcs_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // vcell_raw, vcell_ok, soc_raw, soc_ok, temp_reading, temp_ok,
  // charger_present, charging_active, charger_full_flag, now_seconds, zero fill
  logic [87:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // soc_percent, vcell_uv, health, charge_state, charge_drive, supply_status, changed
  logic [39:0] out_tdata;
  logic        cfg_wr_en;
  logic [2:0]  cfg_addr;
  logic [22:0] cfg_wdata;

  typedef struct packed {
    logic [31:0] now_s;
    logic        full_flag;
    logic        chg_active;
    logic        present;
    logic        temp_ok;
    logic [11:0] temp;
    logic        soc_ok;
    logic [15:0] soc_raw;
    logic        vcell_ok;
    logic [15:0] vcell_raw;
  } poll_t;

  typedef struct packed {
    logic       changed;
    logic [2:0] status;
    logic [1:0] drive;
    logic [1:0] chg;
    logic [1:0] health;
    logic [22:0] vcell;
    logic [6:0] soc;
  } report_t;

  battery_charge_supervisor_core uut (.*);

  // Predictor copy of registers and state
  logic [6:0]         m_min_cap;
  logic signed [11:0] m_hi_block, m_hi_rec, m_lo_rec, m_lo_block;
  logic [22:0]        m_full_uv, m_rechg_uv;
  logic [15:0]        m_limit;
  logic [22:0]        s_vcell;
  logic [6:0]         s_soc;
  logic signed [11:0] s_temp;
  logic [1:0]         s_health, s_chg;
  logic [31:0]        s_deadline;
  logic               s_rechg;
  logic [2:0]         s_status;

  report_t     expected_reports[$];
  int          errors;
  int          polls_sent;
  int          reports_seen;
  int          idle_cycles;
  bit          long_hold;
  bit          rx_fast;
  bit          tx_fast;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if no word moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("watchdog expired");
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [6:0] soc_rescale(logic [15:0] raw);
    logic [63:0] mm, fmin, v, d;
    mm = m_min_cap;
    fmin = mm << 8;
    if (raw <= fmin) return 7'd0;
    if (mm > 99) begin
      mm = 99;
      fmin = mm << 8;
    end
    v = (64'd25600 * (raw - fmin) + 128) >> 8;
    d = 64'd25600 - fmin;
    v = ((v << 8) + (d >> 1)) / d;
    v = v >> 8;
    return (v > 100) ? 7'd100 : v[6:0];
  endfunction

  function automatic bit temp_recovered();
    return s_temp <= m_hi_rec && s_temp >= m_lo_rec;
  endfunction

  // Advance the predictor by one poll and return the expected report
  function automatic report_t supervise(poll_t p);
    report_t r;
    logic [6:0] last_soc;
    logic [2:0] last_status;
    logic [1:0] drv;
    last_soc = s_soc;
    last_status = s_status;
    drv = DRV_NONE;
    if (p.vcell_ok) s_vcell = 23'(p.vcell_raw[15:4] * 23'd1250);
    if (p.soc_ok) s_soc = soc_rescale(p.soc_raw);
    if (p.temp_ok) begin
      s_temp = p.temp;
      if (s_temp >= m_hi_block) s_health = HEALTH_HOT;
      else if (temp_recovered()) s_health = HEALTH_GOOD;
      else if (s_temp <= m_lo_block) s_health = HEALTH_COLD;
    end else begin
      s_health = HEALTH_UNKNOWN;
    end
    if (p.present) begin
      case (s_chg)
        CHG_OK: begin
          if (p.full_flag && s_soc >= 7'd100 && s_vcell > m_full_uv) begin
            s_chg = CHG_FULL; s_rechg = 1'b1; s_deadline = '0; drv = DRV_DISABLE;
          end else if (s_deadline != 0 && p.now_s > s_deadline) begin
            s_chg = CHG_TIMEOUT; s_rechg = 1'b1; s_deadline = '0; drv = DRV_DISABLE;
          end else if (s_health == HEALTH_HOT || s_health == HEALTH_COLD) begin
            s_chg = CHG_BAD_TEMP; s_deadline = '0; drv = DRV_DISABLE;
          end
        end
        CHG_FULL:
          if (s_vcell <= m_rechg_uv) begin s_chg = CHG_OK; drv = DRV_ENABLE; end
        CHG_BAD_TEMP:
          if (temp_recovered()) begin s_chg = CHG_OK; drv = DRV_ENABLE; end
        default:
          if (s_vcell <= m_full_uv) begin s_chg = CHG_OK; drv = DRV_ENABLE; end
      endcase
      if (s_deadline == 0 && s_chg == CHG_OK)
        s_deadline = p.now_s + (s_rechg ? RECHARGE_LIMIT_S : {16'd0, m_limit});
      if (p.chg_active) s_status = STAT_CHARGING;
      else s_status = (s_chg == CHG_FULL) ? STAT_FULL : STAT_NOT_CHG;
    end else begin
      s_rechg = 1'b0;
      s_status = STAT_DISCHG;
      s_deadline = '0;
      s_chg = CHG_OK;
    end
    r.soc = s_soc;
    r.vcell = s_vcell;
    r.health = s_health;
    r.chg = s_chg;
    r.drive = drv;
    r.status = s_status;
    r.changed = (s_soc != last_soc) || (s_status != last_status);
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    errors++;
    if (errors <= 30)
      $display("mismatch report %0d %s: got %0d want %0d", reports_seen, field, got, want);
  endtask

  // Check each report against the oldest expectation
  always @(posedge clk) begin
    report_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected", 0, 0);
      end else begin
        want = expected_reports.pop_front();
        if (got.soc != want.soc) report_mismatch("soc", got.soc, want.soc);
        if (got.vcell != want.vcell) report_mismatch("vcell", got.vcell, want.vcell);
        if (got.health != want.health) report_mismatch("health", got.health, want.health);
        if (got.chg != want.chg) report_mismatch("charge_state", got.chg, want.chg);
        if (got.drive != want.drive) report_mismatch("drive", got.drive, want.drive);
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.changed != want.changed)
          report_mismatch("changed", got.changed, want.changed);
      end
      reports_seen++;
    end
  end

  // Receiver stalls: random gaps, one long hold on request
  initial begin
    int n;
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 0;
        repeat (600) @(negedge clk);
        long_hold = 0;
      end else if (rx_fast || $urandom_range(0, 2) != 0) begin
        out_tready <= 1;
      end else begin
        out_tready <= 0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
        repeat (n) @(negedge clk);
      end
    end
  end

  // Offer one word after an idle gap, hold it until taken
  task automatic send_poll(poll_t p);
    int gap;
    if (tx_fast)
      gap = 1;
    else
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3);
    repeat (gap) @(negedge clk);
    in_tdata <= {6'd0, p};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_reports.push_back(supervise(p));
    polls_sent++;
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  task automatic wait_drained();
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [22:0] val);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MIN_CAP:    m_min_cap = val[6:0];
      REG_HIGH_BLOCK: m_hi_block = val[11:0];
      REG_HIGH_REC:   m_hi_rec = val[11:0];
      REG_LOW_REC:    m_lo_rec = val[11:0];
      REG_LOW_BLOCK:  m_lo_block = val[11:0];
      REG_FULL_UV:    m_full_uv = val;
      REG_RECHG_UV:   m_rechg_uv = val;
      default:        m_limit = val[15:0];
    endcase
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic write_defaults();
    write_reg(REG_MIN_CAP, 23'd0);
    write_reg(REG_HIGH_BLOCK, 23'(12'sd500));
    write_reg(REG_HIGH_REC, 23'(12'sd420));
    write_reg(REG_LOW_REC, 23'd0);
    write_reg(REG_LOW_BLOCK, 23'(12'hFCE));
    write_reg(REG_FULL_UV, 23'd4150000);
    write_reg(REG_RECHG_UV, 23'd4140000);
    write_reg(REG_LIMIT_S, 23'd21600);
  endtask

  function automatic poll_t random_poll(logic [31:0] now_s);
    poll_t p;
    p = 82'({$urandom, $urandom, $urandom});
    p.vcell_ok = ($urandom_range(0, 7) != 0);
    p.soc_ok = ($urandom_range(0, 7) != 0);
    p.temp_ok = ($urandom_range(0, 7) != 0);
    p.present = ($urandom_range(0, 9) != 0);
    // Mostly plausible readings around the thresholds
    if ($urandom_range(0, 3) != 0) begin
      p.vcell_raw = 16'(($urandom_range(4100000, 4200000) / 1250) << 4) | 16'($urandom_range(0, 15));
      p.soc_raw = 16'($urandom_range(0, 26000));
      p.temp = 12'($signed($urandom_range(0, 700)) - 100);
      p.now_s = now_s;
    end
    return p;
  endfunction

  // Directed: extremes, failed reads, every charge state path
  task automatic test_directed();
    poll_t p;
    p = '0;
    send_poll(p);
    p = '1;
    send_poll(p);
    p = '0; p.present = 1; p.vcell_ok = 1; p.soc_ok = 1; p.temp_ok = 1;
    p.vcell_raw = 16'hFFFF; p.soc_raw = 16'hFFFF; p.temp = 12'd250; p.now_s = 100;
    send_poll(p);
    p.full_flag = 1; p.now_s = 200;
    send_poll(p);                  // full
    p.vcell_raw = 16'h0100; p.full_flag = 0;
    send_poll(p);                  // resume
    p.now_s = 32'd100000;
    send_poll(p);                  // timeout
    p.vcell_ok = 0; p.soc_ok = 0; p.temp_ok = 0;
    send_poll(p);                  // failed reads
    p.vcell_ok = 1; p.temp_ok = 1; p.temp = 12'h800;
    send_poll(p);                  // cold
    p.temp = 12'd800;
    send_poll(p);                  // hot
    p.temp = 12'd450;
    send_poll(p);                  // between bands
    p.temp_ok = 0;
    send_poll(p);
    p.temp_ok = 1; p.temp = 12'd200;
    send_poll(p);                  // recover
    p.now_s = 32'hFFFF_FFFF - 21599;
    send_poll(p);
    p.present = 0;
    send_poll(p);                  // charger absent
    p.present = 1; p.now_s = 32'hFFFF_FFFF; p.temp = 12'h7FF; p.chg_active = 1;
    send_poll(p);
    wait_drained();
  endtask

  // Random sessions with a slowly advancing clock
  task automatic test_random(int count);
    logic [31:0] now_s;
    now_s = $urandom;
    repeat (count) begin
      now_s = now_s + $urandom_range(0, 3000);
      send_poll(random_poll(now_s));
    end
    wait_drained();
  endtask

  // Extreme register settings
  task automatic test_config_extremes();
    write_reg(REG_MIN_CAP, 23'd127);
    write_reg(REG_HIGH_BLOCK, 23'(12'h7FF));
    write_reg(REG_HIGH_REC, 23'(12'h7FF));
    write_reg(REG_LOW_REC, 23'(12'h800));
    write_reg(REG_LOW_BLOCK, 23'(12'h800));
    write_reg(REG_FULL_UV, 23'd5118750);
    write_reg(REG_RECHG_UV, 23'd0);
    write_reg(REG_LIMIT_S, 23'd1);
    test_random(150);
    write_reg(REG_MIN_CAP, 23'd99);
    write_reg(REG_HIGH_BLOCK, 23'(12'h800));
    write_reg(REG_FULL_UV, 23'd0);
    write_reg(REG_RECHG_UV, 23'd5118750);
    write_reg(REG_LIMIT_S, 23'd65535);
    test_random(150);
    write_reg(REG_MIN_CAP, 23'd40);
    write_reg(REG_HIGH_BLOCK, 23'd300);
    write_reg(REG_HIGH_REC, 23'd250);
    write_reg(REG_LOW_REC, 23'd100);
    write_reg(REG_LOW_BLOCK, 23'd50);
    write_reg(REG_FULL_UV, 23'd4160000);
    write_reg(REG_RECHG_UV, 23'd4120000);
    write_reg(REG_LIMIT_S, 23'd3000);
    test_random(250);
  endtask

  // Hold the receiver off while polls keep coming
  task automatic test_backpressure();
    long_hold = 1;
    tx_fast = 1;
    test_random(40);
    tx_fast = 0;
    rx_fast = 1;
    test_random(100);
    rx_fast = 0;
  endtask

  initial begin
    errors = 0; polls_sent = 0; reports_seen = 0; idle_cycles = 0;
    long_hold = 0; rx_fast = 0; tx_fast = 0;
    in_tvalid = 0; in_tdata = '0;
    cfg_wr_en = 0; cfg_addr = '0; cfg_wdata = '0;
    m_min_cap = 7'd0; m_hi_block = 12'sd500; m_hi_rec = 12'sd420; m_lo_rec = 12'sd0;
    m_lo_block = -12'sd50;
    m_full_uv = 23'd4150000; m_rechg_uv = 23'd4140000; m_limit = 16'd21600;
    s_vcell = '0; s_soc = '0; s_temp = '0; s_health = HEALTH_GOOD; s_chg = CHG_OK;
    s_deadline = '0; s_rechg = 1'b0; s_status = STAT_UNKNOWN;
    rst_n = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_random(700);
    test_config_extremes();
    write_defaults();
    test_backpressure();
    wait_drained();
    $display("sent %0d polls, checked %0d reports across %0d register settings",
             polls_sent, reports_seen, 5);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
